// ===== sv/bums_pkg.sv =====
// ----------------------------------------------------------------------------
// bums_pkg
// Shared types and constants of the bottom-up merge sorter.
// ----------------------------------------------------------------------------
package bums_pkg;

   localparam int KEY_W         = 32;
   localparam int MAX_ITEMS_DEF = 64;

   // write/read steering between the sequencer and the key stores
   typedef struct packed {
      logic wr_en;    // write one entry this cycle
      logic wr_dst;   // 0: key store, 1: work store
      logic src_sel;  // store that the reads issued this cycle come from
   } st_ctl_type;

endpackage

// ===== sv/bums_if.sv =====
// ----------------------------------------------------------------------------
// bums_req_if / bums_rsp_if
// Valid/ready channels of the merge sorter: keys in, sorted keys out.
// ----------------------------------------------------------------------------
interface bums_req_if;
   import bums_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [KEY_W-1:0] key_value;
   logic                    is_last;

   modport source (output valid, output key_value, output is_last, input ready);
   modport sink   (input valid, input key_value, input is_last, output ready);
endinterface

interface bums_rsp_if;
   import bums_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [KEY_W-1:0] sorted_value;
   logic                    is_final;

   modport source (output valid, output sorted_value, output is_final, input ready);
   modport sink   (input valid, input sorted_value, input is_final, output ready);
endinterface

// ===== sv/bums_store.sv =====
// ----------------------------------------------------------------------------
// bums_store
// Key store and work store used as a ping-pong pair, two read ports each,
// registered reads with write-to-read forwarding.
// ----------------------------------------------------------------------------
module bums_store #(
   parameter int MAX_ITEMS = bums_pkg::MAX_ITEMS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bums_pkg::st_ctl_type                 ctl,
   input  logic [$clog2(MAX_ITEMS)-1:0]         wr_addr,
   input  logic signed [bums_pkg::KEY_W-1:0]    wr_data,
   input  logic [$clog2(MAX_ITEMS)-1:0]         rd_addr_a,
   input  logic [$clog2(MAX_ITEMS)-1:0]         rd_addr_b,
   output logic signed [bums_pkg::KEY_W-1:0]    head_a,
   output logic signed [bums_pkg::KEY_W-1:0]    head_b
);
   import bums_pkg::*;

   logic signed [KEY_W-1:0] key_store  [MAX_ITEMS];
   logic signed [KEY_W-1:0] work_store [MAX_ITEMS];

   logic signed [KEY_W-1:0] ks_a_ff, ks_b_ff, ws_a_ff, ws_b_ff;
   logic                    sel_ff;
   logic                    ks_wr, ws_wr;

   assign ks_wr = ctl.wr_en && !ctl.wr_dst;
   assign ws_wr = ctl.wr_en &&  ctl.wr_dst;

   always_ff @(posedge clock) begin
      if (ks_wr) begin
         key_store[wr_addr] <= wr_data;
      end
      if (ws_wr) begin
         work_store[wr_addr] <= wr_data;
      end
   end

   // a read of the entry written in the same cycle returns the new key
   always_ff @(posedge clock) begin
      ks_a_ff <= (ks_wr && wr_addr == rd_addr_a) ? wr_data : key_store[rd_addr_a];
      ks_b_ff <= (ks_wr && wr_addr == rd_addr_b) ? wr_data : key_store[rd_addr_b];
      ws_a_ff <= (ws_wr && wr_addr == rd_addr_a) ? wr_data : work_store[rd_addr_a];
      ws_b_ff <= (ws_wr && wr_addr == rd_addr_b) ? wr_data : work_store[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= 1'b0;
      end else begin
         sel_ff <= ctl.src_sel;
      end
   end

   assign head_a = sel_ff ? ws_a_ff : ks_a_ff;
   assign head_b = sel_ff ? ws_b_ff : ks_b_ff;

endmodule

// ===== sv/bottom_up_merge_sort.sv =====
// ----------------------------------------------------------------------------
// bottom_up_merge_sort
// Loads signed keys until one marked last, sorts them ascending by bottom-up
// merging and streams them out with the greatest key marked final.
// ----------------------------------------------------------------------------
// Keys are taken one per cycle while the block is loading; a key arriving
// with MAX_ITEMS keys already held is dropped (a last mark on it still starts
// the sort). For n keys the sort runs ceil(log2 n) passes; in each pass every
// pair of runs gets a setup state and is then merged, one merged key per cycle
// through the two read ports of the source store, with the two stores
// swapping roles between passes. The sorted keys then leave at one per cycle
// while the consumer keeps up. No input is taken from the last key of a set
// until the final sorted key has been loaded into the output register.
// ----------------------------------------------------------------------------
module bottom_up_merge_sort #(
   parameter int MAX_ITEMS = bums_pkg::MAX_ITEMS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   bums_req_if.sink   req,
   bums_rsp_if.source rsp
);
   import bums_pkg::*;

   localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
   localparam int ADDR_W = $clog2(MAX_ITEMS);

   localparam logic [1:0] ST_LOAD  = 2'd0;
   localparam logic [1:0] ST_SETUP = 2'd1;
   localparam logic [1:0] ST_MERGE = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] run_ff, run_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] a_ptr_ff, a_ptr_in, a_end_ff, a_end_in;
   logic [CNT_W-1:0] b_ptr_ff, b_ptr_in, b_end_ff, b_end_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic             sel_ff, sel_in;
   logic             out_valid_ff, out_valid_in;
   logic             out_final_ff, out_final_in;
   logic signed [KEY_W-1:0] out_key_ff, out_key_in;

   st_ctl_type              ctl;
   logic [ADDR_W-1:0]       wr_addr;
   logic signed [KEY_W-1:0] wr_data;
   logic signed [KEY_W-1:0] head_a, head_b;

   logic             req_fire, rsp_fire, room, a_ok, b_ok, take_a, emit_adv;
   logic [CNT_W-1:0] n_new, rem, rem_b, la, lb;
   logic [CNT_W:0]   lo_nxt, run_dbl;

   assign req_fire = req.valid && req.ready;
   assign rsp_fire = out_valid_ff && rsp.ready;
   assign room     = count_ff < CNT_W'(MAX_ITEMS);
   assign n_new    = count_ff + CNT_W'(room);

   // run boundaries of the pair starting at lo; a short or missing right run
   // falls out of the clamps
   assign rem     = n_ff - lo_ff;
   assign la      = (run_ff < rem) ? run_ff : rem;
   assign rem_b   = rem - la;
   assign lb      = (run_ff < rem_b) ? run_ff : rem_b;
   assign lo_nxt  = {1'b0, lo_ff} + {run_ff, 1'b0};
   assign run_dbl = {run_ff, 1'b0};

   // ties take the right-hand run
   assign a_ok   = a_ptr_ff < a_end_ff;
   assign b_ok   = b_ptr_ff < b_end_ff;
   assign take_a = a_ok && (!b_ok || (head_a < head_b));

   assign emit_adv = (state_ff == ST_EMIT) && (!out_valid_ff || rsp.ready);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      n_in         = n_ff;
      run_in       = run_ff;
      lo_in        = lo_ff;
      a_ptr_in     = a_ptr_ff;
      a_end_in     = a_end_ff;
      b_ptr_in     = b_ptr_ff;
      b_end_in     = b_end_ff;
      k_in         = k_ff;
      sel_in       = sel_ff;
      out_valid_in = out_valid_ff && !rsp_fire;
      out_key_in   = out_key_ff;
      out_final_in = out_final_ff;
      ctl          = '0;
      wr_addr      = count_ff[ADDR_W-1:0];
      wr_data      = req.key_value;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (room) begin
                  ctl.wr_en = 1'b1;
                  count_in  = count_ff + 1'b1;
               end
               if (req.is_last) begin
                  n_in     = n_new;
                  count_in = '0;
                  run_in   = CNT_W'(1);
                  lo_in    = '0;
                  sel_in   = 1'b0;
                  a_ptr_in = '0;
                  state_in = (n_new > CNT_W'(1)) ? ST_SETUP : ST_EMIT;
               end
            end
         end
         ST_SETUP: begin
            a_ptr_in = lo_ff;
            a_end_in = lo_ff + la;
            b_ptr_in = lo_ff + la;
            b_end_in = lo_ff + la + lb;
            k_in     = lo_ff;
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            ctl.wr_en  = 1'b1;
            ctl.wr_dst = !sel_ff;
            wr_addr    = k_ff[ADDR_W-1:0];
            wr_data    = take_a ? head_a : head_b;
            k_in       = k_ff + 1'b1;
            if (take_a) begin
               a_ptr_in = a_ptr_ff + 1'b1;
            end else begin
               b_ptr_in = b_ptr_ff + 1'b1;
            end
            if (k_ff + 1'b1 == b_end_ff) begin
               if (lo_nxt >= {1'b0, n_ff}) begin
                  // pass done: output store becomes the source
                  run_in = run_dbl[CNT_W-1:0];
                  sel_in = !sel_ff;
                  lo_in  = '0;
                  if (run_dbl >= {1'b0, n_ff}) begin
                     a_ptr_in = '0;
                     state_in = ST_EMIT;
                  end else begin
                     state_in = ST_SETUP;
                  end
               end else begin
                  lo_in    = lo_nxt[CNT_W-1:0];
                  state_in = ST_SETUP;
               end
            end
         end
         ST_EMIT: begin
            if (emit_adv) begin
               out_valid_in = 1'b1;
               out_key_in   = head_a;
               out_final_in = (a_ptr_ff + 1'b1 == n_ff);
               a_ptr_in     = a_ptr_ff + 1'b1;
               if (a_ptr_ff + 1'b1 == n_ff) begin
                  state_in = ST_LOAD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase

      ctl.src_sel = sel_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         n_ff         <= '0;
         run_ff       <= CNT_W'(1);
         lo_ff        <= '0;
         a_ptr_ff     <= '0;
         a_end_ff     <= '0;
         b_ptr_ff     <= '0;
         b_end_ff     <= '0;
         k_ff         <= '0;
         sel_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         n_ff         <= n_in;
         run_ff       <= run_in;
         lo_ff        <= lo_in;
         a_ptr_ff     <= a_ptr_in;
         a_end_ff     <= a_end_in;
         b_ptr_ff     <= b_ptr_in;
         b_end_ff     <= b_end_in;
         k_ff         <= k_in;
         sel_ff       <= sel_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_key_ff   <= out_key_in;
      out_final_ff <= out_final_in;
   end

   bums_store #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (a_ptr_in[ADDR_W-1:0]),
      .rd_addr_b (b_ptr_in[ADDR_W-1:0]),
      .head_a    (head_a),
      .head_b    (head_b)
   );

   assign req.ready        = (state_ff == ST_LOAD);
   assign rsp.valid        = out_valid_ff;
   assign rsp.sorted_value = out_key_ff;
   assign rsp.is_final     = out_final_ff;

endmodule

// ===== sv/bums_check.sv =====
// ----------------------------------------------------------------------------
// bums_check
// Port-level checks of the merge sorter, bound to the top level.
// ----------------------------------------------------------------------------
module bums_check (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             req_is_last,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic signed [bums_pkg::KEY_W-1:0] rsp_sorted_value,
   input logic                             rsp_is_final
);

   // a stalled result transaction holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sorted_value)
                                  && $stable(rsp_is_final))
      else $error("result changed while stalled");

   // the last key of a set closes the input until the set is emitted
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_is_last |=> !req_ready)
      else $error("input open right after last key");

   // more results of the set are due: the next one follows at once
   a_burst_closed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_is_final |=> rsp_valid)
      else $error("gap in the middle of a result burst");

   // while loading, only the final key of the previous set may be pending
   a_load_clean: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid || rsp_is_final)
      else $error("non-final result pending while loading");

endmodule

bind bottom_up_merge_sort bums_check u_bums_check (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .req_is_last      (req.is_last),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_sorted_value (rsp.sorted_value),
   .rsp_is_final     (rsp.is_final)
);
